// ===== sv/cvr_pkg.sv =====
package cvr_pkg;

    typedef logic [7:0]  t_pix;
    typedef logic [11:0] t_coef;
    typedef logic [2:0]  t_bank;

    localparam logic [2:0] CFG_COEF0  = 3'd0;
    localparam logic [2:0] CFG_COEF4  = 3'd4;
    localparam logic [2:0] CFG_WIDTH  = 3'd5;
    localparam logic [2:0] CFG_HEIGHT = 3'd6;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [59:0] COEF_RESET   = 60'd11543292231716905;
    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [15:0] HEIGHT_RESET = 16'd1024;

    localparam int TAPS       = 5;
    localparam int BANKS      = 8;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

endpackage

// ===== sv/cvr_ram.sv =====
module cvr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/conv5x5_reflect_border.sv =====
// 5x5 convolution over an 8-bit grayscale raster stream with reflect-101
// borders. The block takes one item per clock, pixel or flush, unless input
// is stalled, and returns at most one filtered pixel per item; each output
// lags its input by two rows and two columns, and after the last pixel of a
// frame each flush item (or pixel item, whose pixel is dropped) drains one
// more output until the bottom-right pixel, which carries frame_end. Frame
// size is latched at the first pixel of a frame. Pixels live in eight line
// memories, one per row modulo eight, all read at the same column each
// cycle; one column of five mirrored rows is fetched per item and shifted
// into a five-column window, so the sustained rate is one item per cycle
// while input is not stalled, set by the single read port of each line
// memory. An item's result passes the stage 1 to stage 4 registers before
// it enters the output queue. The output queue holds eight results and
// input is stalled only while eight results are owed to the output side.
// There is no clearing pass after reset: no output ever reads a line entry
// that the current frame has not written.
module conv5x5_reflect_border #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_pixel,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_blurred,
    output logic        o_last_of_item,
    output logic        o_frame_end,
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [59:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int LW = CW + 2;
    localparam int RW = 16;
    localparam int RST_FW = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int FIFO_CWX = cvr_pkg::FIFO_CW;

    // ---------------------------------------------------------------- config
    logic [59:0] r_coef [cvr_pkg::TAPS];
    logic [10:0] r_img_w;
    logic [15:0] r_img_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cvr_pkg::TAPS; i++) begin
                r_coef[i] <= cvr_pkg::COEF_RESET;
            end
            r_img_w <= cvr_pkg::WIDTH_RESET;
            r_img_h <= cvr_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index inside {[cvr_pkg::CFG_COEF0:cvr_pkg::CFG_COEF4]}) begin
                r_coef[i_cfg_index] <= i_cfg_data;
            end else if (i_cfg_index == cvr_pkg::CFG_WIDTH) begin
                r_img_w <= i_cfg_data[10:0];
            end else if (i_cfg_index == cvr_pkg::CFG_HEIGHT) begin
                r_img_h <= i_cfg_data[15:0];
            end
        end
    end

    // clamp geometry: width to 3..MAX_WIDTH, height to at least 3
    logic [CW-1:0] w_clamp;
    logic [RW-1:0] h_clamp;

    always_comb begin
        if (r_img_w < 11'd3) begin
            w_clamp = CW'(3);
        end else if (32'(r_img_w) > 32'(MAX_WIDTH)) begin
            w_clamp = CW'(MAX_WIDTH);
        end else begin
            w_clamp = CW'(r_img_w);
        end
        h_clamp = (r_img_h < 16'd3) ? 16'd3 : r_img_h;
    end

    // ------------------------------------------------------- stream control
    logic [CW-1:0] r_fw, n_fw;
    logic [RW-1:0] r_fh, n_fh;
    logic [CW-1:0] r_in_col, n_in_col;
    logic [RW-1:0] r_in_row, n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;
    logic [CW-1:0] r_fc, n_fc;
    logic [RW-1:0] r_fr, n_fr;
    logic          r_in_done, n_in_done;
    logic [LW-1:0] r_lead, n_lead;

    logic [FIFO_CWX-1:0] r_cnt;

    logic          acc, pix_path, emit0, fetch0, last0;
    logic [LW-1:0] lead_full, lead_fetch;
    logic [CW-1:0] in_col_inc, out_col_inc, fc_inc;

    assign o_in_stall = (r_cnt == FIFO_CWX'(cvr_pkg::FIFO_DEPTH));
    assign acc        = i_in_valid && !o_in_stall;
    // a pixel that arrives after the frame's input is complete is a flush
    assign pix_path   = acc && (i_opcode == cvr_pkg::OP_PIXEL) && !r_in_done;

    always_comb begin
        n_fw = r_fw;
        n_fh = r_fh;
        if (pix_path && r_in_row == '0 && r_in_col == '0) begin
            n_fw = w_clamp;
            n_fh = h_clamp;
        end
        lead_full  = LW'({n_fw, 1'b0}) + LW'(2);
        lead_fetch = LW'({n_fw, 1'b0});
        emit0  = acc && (r_in_done || (pix_path && r_lead >= lead_full));
        fetch0 = emit0 || (pix_path && r_lead >= lead_fetch);
        last0  = (r_out_row == n_fh - 16'd1) && (r_out_col == n_fw - CW'(1));

        in_col_inc  = r_in_col + CW'(1);
        out_col_inc = r_out_col + CW'(1);
        fc_inc      = r_fc + CW'(1);

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_in_done = r_in_done;
        n_lead    = r_lead;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_fc      = r_fc;
        n_fr      = r_fr;

        if (pix_path) begin
            if (in_col_inc >= n_fw) begin
                n_in_col = '0;
                n_in_row = r_in_row + 16'd1;
                if (r_in_row + 16'd1 >= n_fh) begin
                    n_in_done = 1'b1;
                end
            end else begin
                n_in_col = in_col_inc;
            end
            if (r_lead < lead_full) begin
                n_lead = r_lead + LW'(1);
            end
        end
        // fetch stream runs two columns ahead of the output position
        if (fetch0) begin
            if (fc_inc >= n_fw) begin
                n_fc = '0;
                n_fr = r_fr + 16'd1;
            end else begin
                n_fc = fc_inc;
            end
        end
        if (emit0) begin
            if (last0) begin
                // frame done: clear every position for the next frame
                n_in_col  = '0;
                n_in_row  = '0;
                n_in_done = 1'b0;
                n_lead    = '0;
                n_out_col = '0;
                n_out_row = '0;
                n_fc      = '0;
                n_fr      = '0;
            end else if (out_col_inc >= n_fw) begin
                n_out_col = '0;
                n_out_row = r_out_row + 16'd1;
            end else begin
                n_out_col = out_col_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw      <= CW'(RST_FW);
            r_fh      <= cvr_pkg::HEIGHT_RESET;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_fc      <= '0;
            r_fr      <= '0;
            r_in_done <= 1'b0;
            r_lead    <= '0;
        end else begin
            r_fw      <= n_fw;
            r_fh      <= n_fh;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_fc      <= n_fc;
            r_fr      <= n_fr;
            r_in_done <= n_in_done;
            r_lead    <= n_lead;
        end
    end

    // ------------------------------------------------- fetch row selection
    // banks of rows fr-2..fr+2, mirrored about the top and bottom rows
    cvr_pkg::t_bank fb [cvr_pkg::TAPS];
    cvr_pkg::t_bank r3;
    logic           top0, top1, bot1, bot2;

    always_comb begin
        r3   = r_fr[2:0];
        top0 = (r_fr == 16'd0);
        top1 = (r_fr == 16'd1);
        bot1 = ({1'b0, r_fr} + 17'd1) >= {1'b0, n_fh};
        bot2 = ({1'b0, r_fr} + 17'd2) >= {1'b0, n_fh};
        fb[0] = top0 ? 3'd2 : (top1 ? 3'd1 : r3 - 3'd2);
        fb[1] = top0 ? 3'd1 : r3 - 3'd1;
        fb[2] = r3;
        fb[3] = bot1 ? r3 - 3'd1 : r3 + 3'd1;
        fb[4] = bot2 ? ({n_fh[1:0], 1'b0} - 3'd4 - r3) : r3 + 3'd2;
    end

    // ------------------------------------------------------- line memories
    cvr_pkg::t_pix rdata [cvr_pkg::BANKS];
    logic [AW-1:0] waddr, raddr;
    cvr_pkg::t_bank wbank;

    assign waddr = r_in_col[AW-1:0];
    assign raddr = r_fc[AW-1:0];
    assign wbank = r_in_row[2:0];

    for (genvar b = 0; b < cvr_pkg::BANKS; b++) begin : g_bank
        cvr_ram #(
            .WIDTH (8),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (pix_path && wbank == 3'(b)),
            .i_waddr (waddr),
            .i_wdata (i_pixel),
            .i_raddr (raddr),
            .o_rdata (rdata[b])
        );
    end

    // -------------------------------------------------------------- stage 1
    logic           r_v1, r_f1, r_l1;
    cvr_pkg::t_bank r_b1 [cvr_pkg::TAPS];
    logic           r_fwd1;
    cvr_pkg::t_bank r_fwb1;
    cvr_pkg::t_pix  r_fwp1;
    logic           r_c0, r_c1, r_cw2, r_cw1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_f1 <= 1'b0;
        end else begin
            r_v1 <= emit0;
            r_f1 <= fetch0;
        end
        r_l1   <= last0;
        r_b1   <= fb;
        // the pixel written this cycle is the one the fetch needs: bypass
        r_fwd1 <= pix_path && waddr == raddr;
        r_fwb1 <= wbank;
        r_fwp1 <= i_pixel;
        r_c0   <= (r_out_col == CW'(0));
        r_c1   <= (r_out_col == CW'(1));
        r_cw2  <= (r_out_col + CW'(2) == n_fw);
        r_cw1  <= (out_col_inc == n_fw);
    end

    cvr_pkg::t_pix col   [cvr_pkg::TAPS];
    cvr_pkg::t_pix jc    [cvr_pkg::TAPS][cvr_pkg::TAPS];
    cvr_pkg::t_pix r_sr  [cvr_pkg::TAPS-1][cvr_pkg::TAPS];
    cvr_pkg::t_pix wsel  [cvr_pkg::TAPS][cvr_pkg::TAPS];

    always_comb begin
        for (int u = 0; u < cvr_pkg::TAPS; u++) begin
            col[u] = (r_fwd1 && r_fwb1 == r_b1[u]) ? r_fwp1 : rdata[r_b1[u]];
            jc[0][u] = col[u];
            for (int k = 1; k < cvr_pkg::TAPS; k++) begin
                jc[k][u] = r_sr[k-1][u];
            end
            // mirror columns at the left and right edges
            wsel[u][0] = r_c0 ? jc[0][u] : (r_c1 ? jc[2][u] : jc[4][u]);
            wsel[u][1] = r_c0 ? jc[1][u] : jc[3][u];
            wsel[u][2] = jc[2][u];
            wsel[u][3] = r_cw1 ? jc[3][u] : jc[1][u];
            wsel[u][4] = r_cw1 ? jc[4][u] : (r_cw2 ? jc[2][u] : jc[0][u]);
        end
    end

    // -------------------------------------------------------------- stage 2
    logic          r_v2, r_l2;
    cvr_pkg::t_pix r_win [cvr_pkg::TAPS][cvr_pkg::TAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        if (r_f1) begin
            r_sr[0] <= col;
            for (int k = 1; k < cvr_pkg::TAPS - 1; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
        r_l2  <= r_l1;
        r_win <= wsel;
    end

    // -------------------------------------------------------------- stage 3
    logic        r_v3, r_l3;
    logic [20:0] r_prod [cvr_pkg::TAPS][cvr_pkg::TAPS];
    logic [20:0] prod   [cvr_pkg::TAPS][cvr_pkg::TAPS];

    always_comb begin
        for (int u = 0; u < cvr_pkg::TAPS; u++) begin
            for (int v = 0; v < cvr_pkg::TAPS; v++) begin
                // two's complement product, exact in 21 bits
                prod[u][v] = {{9{r_coef[u][12*v+11]}}, r_coef[u][12*v +: 12]}
                           * {13'd0, r_win[u][v]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_l3   <= r_l2;
        r_prod <= prod;
    end

    // -------------------------------------------------------------- stage 4
    logic        r_v4, r_l4;
    logic [23:0] r_rsum [cvr_pkg::TAPS];
    logic [23:0] rsum   [cvr_pkg::TAPS];

    always_comb begin
        for (int u = 0; u < cvr_pkg::TAPS; u++) begin
            rsum[u] = '0;
            for (int v = 0; v < cvr_pkg::TAPS; v++) begin
                rsum[u] = rsum[u] + {{3{r_prod[u][v][20]}}, r_prod[u][v]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_l4   <= r_l3;
        r_rsum <= rsum;
    end

    // round half up, saturate to 0..255
    logic [26:0]   total;
    cvr_pkg::t_pix res;

    always_comb begin
        total = 27'd512;
        for (int u = 0; u < cvr_pkg::TAPS; u++) begin
            total = total + {{3{r_rsum[u][23]}}, r_rsum[u]};
        end
        if (total[26]) begin
            res = 8'd0;
        end else if (total[25:18] != 8'd0) begin
            res = 8'd255;
        end else begin
            res = total[17:10];
        end
    end

    // ------------------------------------------------------- output queue
    cvr_pkg::t_pix        r_fq_pix [cvr_pkg::FIFO_DEPTH];
    logic                 r_fq_end [cvr_pkg::FIFO_DEPTH];
    logic [cvr_pkg::FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_CWX-1:0]  r_fq_cnt;
    logic                 pop;

    assign o_out_valid    = (r_fq_cnt != '0);
    assign pop            = o_out_valid && !i_out_stall;
    assign o_blurred      = r_fq_pix[r_rp];
    assign o_frame_end    = r_fq_end[r_rp];
    assign o_last_of_item = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_fq_cnt <= '0;
            r_cnt    <= '0;
        end else begin
            if (r_v4) begin
                r_wp <= r_wp + cvr_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + cvr_pkg::FIFO_AW'(1);
            end
            r_fq_cnt <= r_fq_cnt + FIFO_CWX'(r_v4) - FIFO_CWX'(pop);
            // results owed: taken at accept, returned when delivered
            r_cnt    <= r_cnt + FIFO_CWX'(emit0) - FIFO_CWX'(pop);
        end
        if (r_v4) begin
            r_fq_pix[r_wp] <= res;
            r_fq_end[r_wp] <= r_l4;
        end
    end

    // ----------------------------------------------------------- checks
    a_queue_covered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fq_cnt <= r_cnt)
        else $error("output queue holds more results than are owed");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> r_fq_cnt < FIFO_CWX'(cvr_pkg::FIFO_DEPTH))
        else $error("result pushed into a full output queue");

    a_emit_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit0 |-> (r_in_done || r_lead == lead_full))
        else $error("output issued before the two-row lead was filled");

endmodule
